// ===== rtl/gsb_pkg.sv =====
`default_nettype none

package gsb_pkg;

    // Field widths of the channels and the register file
    localparam int SAMPLE_W   = 16;
    localparam int SAMPLE_FRAC = 8;
    localparam int OUT_W      = 32;
    localparam int LEN_W      = 13;
    localparam int COEF_W     = 18;
    localparam int SCALE_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Fraction bits dropped after each kind of product
    localparam int COEF_FRAC  = 16;
    localparam int SCALE_FRAC = 24;

    // Multiplier coefficient operand: signed, wide enough for the unsigned scale
    localparam int MUL_A_W = SCALE_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COSINE_TERM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINE_TERM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE   = 3'd4;

    // Register reset values
    localparam logic        [LEN_W-1:0]   BLOCK_LENGTH_RST   = 13'd960;
    localparam logic signed [COEF_W-1:0]  FEEDBACK_COEFF_RST = 18'sd92682;
    localparam logic signed [COEF_W-1:0]  COSINE_TERM_RST    = 18'sd46341;
    localparam logic signed [COEF_W-1:0]  SINE_TERM_RST      = 18'sd46341;
    localparam logic        [SCALE_W-1:0] OUTPUT_SCALE_RST   = 24'd34953;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_HI,
        S_PSUM,
        S_UPDATE,
        S_F_LO,
        S_F_HI,
        S_F_PSUM,
        S_F_UPDATE,
        S_C_LO,
        S_C_HI,
        S_C_SUM,
        S_DIFF,
        S_R_LO,
        S_R_HI,
        S_R_SUM,
        S_S_LO,
        S_S_HI,
        S_S_SUM,
        S_I_LO,
        S_I_HI,
        S_I_SUM,
        S_EMIT
    } gsb_state_t;

    // Coefficient operand of the shared multiplier
    typedef enum logic [1:0] {
        A_FEEDBACK,
        A_COSINE,
        A_SINE,
        A_SCALE
    } gsb_a_sel_t;

    // Data operand of the shared multiplier
    typedef enum logic [1:0] {
        B_Z1,
        B_ZP,
        B_TERM
    } gsb_b_sel_t;

    // What to do with the two registered partial products
    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_TERM,
        SUM_REAL,
        SUM_IMAG
    } gsb_sum_op_t;

    // Accumulator updates
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_SAMPLE,
        UPD_FINAL,
        UPD_DIFF
    } gsb_upd_op_t;

    typedef struct packed {
        logic        take_sample;
        logic        mul_en;
        logic        mul_hi;
        gsb_a_sel_t  a_sel;
        gsb_b_sel_t  b_sel;
        gsb_sum_op_t sum_op;
        gsb_upd_op_t upd_op;
        logic        load_out;
    } gsb_cmd_t;

    typedef struct packed {
        logic out_free;
    } gsb_status_t;

endpackage

`default_nettype wire

// ===== rtl/gsb_datapath.sv =====
`default_nettype none

module gsb_datapath #(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire gsb_pkg::gsb_cmd_t                    cmd,
    output gsb_pkg::gsb_status_t                      status,
    input  wire logic signed [gsb_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic signed [gsb_pkg::COEF_W-1:0]    feedback_coeff,
    input  wire logic signed [gsb_pkg::COEF_W-1:0]    cosine_term,
    input  wire logic signed [gsb_pkg::COEF_W-1:0]    sine_term,
    input  wire logic        [gsb_pkg::SCALE_W-1:0]   output_scale,
    input  wire logic                                 out_stall,
    output logic                                      out_valid,
    output logic signed [gsb_pkg::OUT_W-1:0]          real_part,
    output logic signed [gsb_pkg::OUT_W-1:0]          imag_part
);

    localparam int LO_W   = ACC_WIDTH / 2;
    localparam int HI_W   = ACC_WIDTH - LO_W;
    localparam int MB_W   = HI_W + 1;
    localparam int MA_W   = gsb_pkg::MUL_A_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int FULL_W = ACC_WIDTH + MA_W;
    localparam int OUT_W  = gsb_pkg::OUT_W;
    localparam int COEF_W = gsb_pkg::COEF_W;
    localparam int XPAD_W = ACC_WIDTH + 1 - gsb_pkg::SAMPLE_W - gsb_pkg::SAMPLE_FRAC;

    localparam logic signed [FULL_W-1:0] ACC_MAX_F =
        {{(FULL_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [FULL_W-1:0] ACC_MIN_F = ~ACC_MAX_F;
    localparam logic signed [FULL_W-1:0] OUT_MAX_F =
        {{(FULL_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [FULL_W-1:0] OUT_MIN_F = ~OUT_MAX_F;

    // Clamp a sum one bit wider than the accumulator
    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
        input logic signed [ACC_WIDTH:0] v
    );
        logic signed [ACC_WIDTH-1:0] r;
        if (v[ACC_WIDTH] != v[ACC_WIDTH-1])
        begin
            r = {v[ACC_WIDTH], {(ACC_WIDTH-1){~v[ACC_WIDTH]}}};
        end
        else
        begin
            r = v[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    logic signed [ACC_WIDTH-1:0]          z1_reg;
    logic signed [ACC_WIDTH-1:0]          z2_reg;
    logic signed [ACC_WIDTH-1:0]          zp_reg;
    logic signed [ACC_WIDTH-1:0]          term_reg;
    logic signed [gsb_pkg::SAMPLE_W-1:0]  x_reg;
    logic signed [PROD_W-1:0]             prod_lo_reg;
    logic signed [PROD_W-1:0]             prod_hi_reg;
    logic signed [OUT_W-1:0]              real_pend_reg;
    logic signed [OUT_W-1:0]              imag_pend_reg;
    logic signed [OUT_W-1:0]              real_reg;
    logic signed [OUT_W-1:0]              imag_reg;
    logic                                 out_valid_reg;

    logic signed [MA_W-1:0]       op_a;
    logic signed [ACC_WIDTH-1:0]  b_val;
    logic signed [MB_W-1:0]       op_b;
    logic signed [PROD_W-1:0]     product;
    logic signed [FULL_W-1:0]     full_sum;
    logic signed [FULL_W-1:0]     shr_coef;
    logic signed [FULL_W-1:0]     shr_scale;
    logic signed [ACC_WIDTH-1:0]  term_sat;
    logic signed [OUT_W-1:0]      out_sat;
    logic signed [ACC_WIDTH:0]    x_ext;
    logic signed [ACC_WIDTH:0]    t_raw;
    logic signed [ACC_WIDTH-1:0]  t_sat;
    logic signed [ACC_WIDTH:0]    w_raw;
    logic signed [ACC_WIDTH-1:0]  w_sat;
    logic signed [ACC_WIDTH:0]    d_raw;
    logic signed [ACC_WIDTH-1:0]  d_sat;

    // Pick the coefficient operand, sign- or zero-extended
    always_comb
    begin
        case (cmd.a_sel)
            gsb_pkg::A_FEEDBACK: op_a = {{(MA_W-COEF_W){feedback_coeff[COEF_W-1]}},
                                         feedback_coeff};
            gsb_pkg::A_COSINE:   op_a = {{(MA_W-COEF_W){cosine_term[COEF_W-1]}},
                                         cosine_term};
            gsb_pkg::A_SINE:     op_a = {{(MA_W-COEF_W){sine_term[COEF_W-1]}},
                                         sine_term};
            gsb_pkg::A_SCALE:    op_a = {1'b0, output_scale};
            default:             op_a = '0;
        endcase
    end

    // Pick the data operand and the half of it for this pass
    always_comb
    begin
        case (cmd.b_sel)
            gsb_pkg::B_Z1:   b_val = z1_reg;
            gsb_pkg::B_ZP:   b_val = zp_reg;
            gsb_pkg::B_TERM: b_val = term_reg;
            default:         b_val = '0;
        endcase
        if (cmd.mul_hi)
        begin
            op_b = {b_val[ACC_WIDTH-1], b_val[ACC_WIDTH-1:LO_W]};
        end
        else
        begin
            op_b = {{(MB_W-LO_W){1'b0}}, b_val[LO_W-1:0]};
        end
    end

    assign product = op_a * op_b;

    // Join the partial products, floor-shift and clamp
    always_comb
    begin
        full_sum  = ({{(FULL_W-PROD_W){prod_hi_reg[PROD_W-1]}}, prod_hi_reg} <<< LO_W)
                  + {{(FULL_W-PROD_W){prod_lo_reg[PROD_W-1]}}, prod_lo_reg};
        shr_coef  = full_sum >>> gsb_pkg::COEF_FRAC;
        shr_scale = full_sum >>> gsb_pkg::SCALE_FRAC;
        if (shr_coef > ACC_MAX_F)
        begin
            term_sat = ACC_MAX_F[ACC_WIDTH-1:0];
        end
        else if (shr_coef < ACC_MIN_F)
        begin
            term_sat = ACC_MIN_F[ACC_WIDTH-1:0];
        end
        else
        begin
            term_sat = shr_coef[ACC_WIDTH-1:0];
        end
        if (shr_scale > OUT_MAX_F)
        begin
            out_sat = OUT_MAX_F[OUT_W-1:0];
        end
        else if (shr_scale < OUT_MIN_F)
        begin
            out_sat = OUT_MIN_F[OUT_W-1:0];
        end
        else
        begin
            out_sat = shr_scale[OUT_W-1:0];
        end
    end

    // Recurrence step and the final difference
    always_comb
    begin
        if (cmd.upd_op == gsb_pkg::UPD_SAMPLE)
        begin
            x_ext = {{XPAD_W{x_reg[gsb_pkg::SAMPLE_W-1]}}, x_reg,
                     {gsb_pkg::SAMPLE_FRAC{1'b0}}};
        end
        else
        begin
            x_ext = '0;
        end
        t_raw = x_ext + {term_reg[ACC_WIDTH-1], term_reg};
        t_sat = sat_acc(t_raw);
        w_raw = {t_sat[ACC_WIDTH-1], t_sat} - {z2_reg[ACC_WIDTH-1], z2_reg};
        w_sat = sat_acc(w_raw);
        d_raw = {z1_reg[ACC_WIDTH-1], z1_reg} - {term_reg[ACC_WIDTH-1], term_reg};
        d_sat = sat_acc(d_raw);
    end

    // Delay line: advance on each step, drop at block end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1_reg <= '0;
            z2_reg <= '0;
        end
        else if (cmd.load_out)
        begin
            z1_reg <= '0;
            z2_reg <= '0;
        end
        else if (cmd.upd_op == gsb_pkg::UPD_SAMPLE || cmd.upd_op == gsb_pkg::UPD_FINAL)
        begin
            z1_reg <= w_sat;
            z2_reg <= z1_reg;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            x_reg <= sample;
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_hi)
            begin
                prod_hi_reg <= product;
            end
            else
            begin
                prod_lo_reg <= product;
            end
        end
        if (cmd.upd_op == gsb_pkg::UPD_FINAL)
        begin
            zp_reg <= z1_reg;
        end
        if (cmd.sum_op == gsb_pkg::SUM_TERM)
        begin
            term_reg <= term_sat;
        end
        else if (cmd.upd_op == gsb_pkg::UPD_DIFF)
        begin
            term_reg <= d_sat;
        end
        if (cmd.sum_op == gsb_pkg::SUM_REAL)
        begin
            real_pend_reg <= out_sat;
        end
        if (cmd.sum_op == gsb_pkg::SUM_IMAG)
        begin
            imag_pend_reg <= out_sat;
        end
        if (cmd.load_out)
        begin
            real_reg <= real_pend_reg;
            imag_reg <= imag_pend_reg;
        end
    end

    // Output beat: set on load, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign real_part       = real_reg;
    assign imag_part       = imag_reg;

endmodule

`default_nettype wire

// ===== rtl/gsb_ctrl.sv =====
`default_nettype none

module gsb_ctrl #(
    parameter int MAX_BLOCK = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [gsb_pkg::LEN_W-1:0]        block_length,
    input  wire gsb_pkg::gsb_status_t             status,
    output gsb_pkg::gsb_cmd_t                     cmd
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int CMP_W = (CNT_W > gsb_pkg::LEN_W) ? CNT_W : gsb_pkg::LEN_W;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_BLOCK);

    gsb_pkg::gsb_state_t state_reg;
    gsb_pkg::gsb_state_t state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] eff_len;
    logic [CMP_W-1:0] count_inc;
    logic             block_end;

    // Effective block length and end-of-block test
    always_comb
    begin
        len_ext = CMP_W'(block_length);
        if (len_ext == '0)
        begin
            eff_len = CMP_W'(1);
        end
        else if (len_ext > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = len_ext;
        end
        count_inc = CMP_W'(count_reg) + CMP_W'(1);
        block_end = (count_inc >= eff_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsb_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cmd.take_sample = 1'b0;
        cmd.mul_en      = 1'b0;
        cmd.mul_hi      = 1'b0;
        cmd.a_sel       = gsb_pkg::A_FEEDBACK;
        cmd.b_sel       = gsb_pkg::B_Z1;
        cmd.sum_op      = gsb_pkg::SUM_NONE;
        cmd.upd_op      = gsb_pkg::UPD_NONE;
        cmd.load_out    = 1'b0;
        case (state_reg)
            gsb_pkg::S_IDLE:
            begin
                // low half of c*z1 runs while waiting for a sample
                cmd.mul_en = 1'b1;
                if (in_valid)
                begin
                    cmd.take_sample = 1'b1;
                    state_next      = gsb_pkg::S_HI;
                end
            end
            gsb_pkg::S_HI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                state_next = gsb_pkg::S_PSUM;
            end
            gsb_pkg::S_PSUM:
            begin
                cmd.sum_op = gsb_pkg::SUM_TERM;
                state_next = gsb_pkg::S_UPDATE;
            end
            gsb_pkg::S_UPDATE:
            begin
                cmd.upd_op = gsb_pkg::UPD_SAMPLE;
                if (block_end)
                begin
                    count_next = '0;
                    state_next = gsb_pkg::S_F_LO;
                end
                else
                begin
                    count_next = count_inc[CNT_W-1:0];
                    state_next = gsb_pkg::S_IDLE;
                end
            end
            // extra step with zero input
            gsb_pkg::S_F_LO:
            begin
                cmd.mul_en = 1'b1;
                state_next = gsb_pkg::S_F_HI;
            end
            gsb_pkg::S_F_HI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                state_next = gsb_pkg::S_F_PSUM;
            end
            gsb_pkg::S_F_PSUM:
            begin
                cmd.sum_op = gsb_pkg::SUM_TERM;
                state_next = gsb_pkg::S_F_UPDATE;
            end
            gsb_pkg::S_F_UPDATE:
            begin
                cmd.upd_op = gsb_pkg::UPD_FINAL;
                state_next = gsb_pkg::S_C_LO;
            end
            // cos * zp
            gsb_pkg::S_C_LO:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = gsb_pkg::A_COSINE;
                cmd.b_sel  = gsb_pkg::B_ZP;
                state_next = gsb_pkg::S_C_HI;
            end
            gsb_pkg::S_C_HI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                cmd.a_sel  = gsb_pkg::A_COSINE;
                cmd.b_sel  = gsb_pkg::B_ZP;
                state_next = gsb_pkg::S_C_SUM;
            end
            gsb_pkg::S_C_SUM:
            begin
                cmd.sum_op = gsb_pkg::SUM_TERM;
                state_next = gsb_pkg::S_DIFF;
            end
            gsb_pkg::S_DIFF:
            begin
                cmd.upd_op = gsb_pkg::UPD_DIFF;
                state_next = gsb_pkg::S_R_LO;
            end
            // real = d * scale
            gsb_pkg::S_R_LO:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = gsb_pkg::A_SCALE;
                cmd.b_sel  = gsb_pkg::B_TERM;
                state_next = gsb_pkg::S_R_HI;
            end
            gsb_pkg::S_R_HI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                cmd.a_sel  = gsb_pkg::A_SCALE;
                cmd.b_sel  = gsb_pkg::B_TERM;
                state_next = gsb_pkg::S_R_SUM;
            end
            gsb_pkg::S_R_SUM:
            begin
                cmd.sum_op = gsb_pkg::SUM_REAL;
                state_next = gsb_pkg::S_S_LO;
            end
            // sin * zp
            gsb_pkg::S_S_LO:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = gsb_pkg::A_SINE;
                cmd.b_sel  = gsb_pkg::B_ZP;
                state_next = gsb_pkg::S_S_HI;
            end
            gsb_pkg::S_S_HI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                cmd.a_sel  = gsb_pkg::A_SINE;
                cmd.b_sel  = gsb_pkg::B_ZP;
                state_next = gsb_pkg::S_S_SUM;
            end
            gsb_pkg::S_S_SUM:
            begin
                cmd.sum_op = gsb_pkg::SUM_TERM;
                state_next = gsb_pkg::S_I_LO;
            end
            // imag = sp * scale
            gsb_pkg::S_I_LO:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = gsb_pkg::A_SCALE;
                cmd.b_sel  = gsb_pkg::B_TERM;
                state_next = gsb_pkg::S_I_HI;
            end
            gsb_pkg::S_I_HI:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                cmd.a_sel  = gsb_pkg::A_SCALE;
                cmd.b_sel  = gsb_pkg::B_TERM;
                state_next = gsb_pkg::S_I_SUM;
            end
            gsb_pkg::S_I_SUM:
            begin
                cmd.sum_op = gsb_pkg::SUM_IMAG;
                state_next = gsb_pkg::S_EMIT;
            end
            // hold until the output register is free
            gsb_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = gsb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gsb_pkg::S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != gsb_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/goertzel_single_bin_top.sv =====
// Channel   Direction  Handshake           Beat contents
// input     in         in_valid/in_stall   sample (16-bit signed)
// output    out        out_valid/out_stall real_part, imag_part (32-bit signed)
// config    in         cfg_write           cfg_index, cfg_data
//
// For each sample, one 25 x (ACC_WIDTH-ACC_WIDTH/2+1) multiplier is shared
// and c*z1 is formed from two partial products before the recurrence updates.
// The last sample of a block adds the zero-input step and the four output
// products, all on the same multiplier.
// A result waits in the output register while the next block is taken; the
// block end holds only if that register is still full.
// rst_n clears the registers to their defaults and the delay line to zero.
`default_nettype none

module goertzel_single_bin_top #(
    parameter int ACC_WIDTH = 48,
    parameter int MAX_BLOCK = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [gsb_pkg::SAMPLE_W-1:0]   sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [gsb_pkg::OUT_W-1:0]           real_part,
    output logic signed [gsb_pkg::OUT_W-1:0]           imag_part,
    input  wire logic                                  cfg_write,
    input  wire logic [gsb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [gsb_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic        [gsb_pkg::LEN_W-1:0]   block_length_reg;
    logic signed [gsb_pkg::COEF_W-1:0]  feedback_coeff_reg;
    logic signed [gsb_pkg::COEF_W-1:0]  cosine_term_reg;
    logic signed [gsb_pkg::COEF_W-1:0]  sine_term_reg;
    logic        [gsb_pkg::SCALE_W-1:0] output_scale_reg;

    gsb_pkg::gsb_cmd_t    cmd;
    gsb_pkg::gsb_status_t status;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg   <= gsb_pkg::BLOCK_LENGTH_RST;
            feedback_coeff_reg <= gsb_pkg::FEEDBACK_COEFF_RST;
            cosine_term_reg    <= gsb_pkg::COSINE_TERM_RST;
            sine_term_reg      <= gsb_pkg::SINE_TERM_RST;
            output_scale_reg   <= gsb_pkg::OUTPUT_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gsb_pkg::CFG_BLOCK_LENGTH:
                    block_length_reg <= cfg_data[gsb_pkg::LEN_W-1:0];
                gsb_pkg::CFG_FEEDBACK_COEFF:
                    feedback_coeff_reg <= signed'(cfg_data[gsb_pkg::COEF_W-1:0]);
                gsb_pkg::CFG_COSINE_TERM:
                    cosine_term_reg <= signed'(cfg_data[gsb_pkg::COEF_W-1:0]);
                gsb_pkg::CFG_SINE_TERM:
                    sine_term_reg <= signed'(cfg_data[gsb_pkg::COEF_W-1:0]);
                gsb_pkg::CFG_OUTPUT_SCALE:
                    output_scale_reg <= cfg_data[gsb_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gsb_ctrl #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .block_length (block_length_reg),
        .status       (status),
        .cmd          (cmd)
    );

    gsb_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .feedback_coeff (feedback_coeff_reg),
        .cosine_term    (cosine_term_reg),
        .sine_term      (sine_term_reg),
        .output_scale   (output_scale_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .real_part      (real_part),
        .imag_part      (imag_part)
    );

endmodule

`default_nettype wire

// ===== rtl/gsb_checker.sv =====
`default_nettype none

module gsb_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [gsb_pkg::OUT_W-1:0]    real_part,
    input wire logic signed [gsb_pkg::OUT_W-1:0]    imag_part
);

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(real_part) && $stable(imag_part))
    else $error("result beat changed while stalled");

    // Result beat only drops once taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
    else $error("result beat dropped without being taken");

    // A sample keeps the input stalled through the high-product, sum and update states of its step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again before the step finished");

    // A new result appears only out of the busy block-end sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while the input side was open");

endmodule

bind goertzel_single_bin_top gsb_checker u_gsb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .real_part (real_part),
    .imag_part (imag_part)
);

`default_nettype wire
